FILE: sv/gaussian_pixel_model_update_unit_macros.svh
// Assertion macros for the Gaussian pixel model update unit checker.
// No dependencies.
`ifndef GAUSSIAN_PIXEL_MODEL_UPDATE_UNIT_MACROS_SVH
`define GAUSSIAN_PIXEL_MODEL_UPDATE_UNIT_MACROS_SVH

// same-cycle implication
`define GPM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/gpm_pkg.sv
// Shared types, constants and the exp table for the Gaussian pixel model update unit.
// No dependencies.
package gpm_pkg;

  localparam int EXP_N = 256;
  localparam int IDX_W = $clog2(EXP_N);
  localparam int DIV_W = 48;
  localparam logic [23:0] MATCH_LIMIT = 24'd1600;
  localparam logic [23:0] DIST_MAX = 24'hFFFFFF;
  localparam logic [25:0] VAR_MAX = 26'h3FFFFFF;
  localparam logic [17:0] SQRT_2PI_Q16 = 18'd164274;
  localparam logic [15:0] LEARN_RATE_RST = 16'd655;
  localparam logic [25:0] INIT_VAR_RST = 26'd5120;
  localparam logic [5:0] NORM_DIV_BITS = 6'd34;
  localparam logic [5:0] RHO_DIV_BITS = 6'd45;

  localparam logic [1:0] OP_QUERY = 2'd0;
  localparam logic [1:0] OP_RESET = 2'd1;
  localparam logic [1:0] OP_ADJUST = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic REG_LEARN_RATE = 1'b0;
  localparam logic REG_INIT_VAR = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_MUL,
    ST_SQ_ACC,
    ST_ND_START,
    ST_ND_WAIT,
    ST_RHO_LR,
    ST_RHO_DEN,
    ST_RD_START,
    ST_RD_WAIT,
    ST_BL_OLD,
    ST_BL_NEW,
    ST_BL_SUM,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic       start;
    logic [5:0] bits;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  typedef logic [15:0] exp_rom_t [EXP_N];

  // shift-subtract quotient of two non-negative values, table build only
  function automatic longint udiv_q(longint n, longint d);
    longint q;
    longint r;
    q = 0;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      r = (r <<< 1) | ((n >>> b) & longint'(1));
      q = q <<< 1;
      if (r >= d) begin
        r = r - d;
        q = q | longint'(1);
      end
    end
    return q;
  endfunction

  // exp(-16k/N) in Q0.16: Taylor series of exp(-k/N) in Q2.30, squared four times
  function automatic exp_rom_t build_exp_rom();
    exp_rom_t rom;
    longint one;
    longint z;
    longint term;
    longint sum;
    one = longint'(1) <<< 30;
    for (int k = 0; k < EXP_N; k++) begin
      z = (longint'(k) <<< 30) / EXP_N;
      term = one;
      sum = one;
      for (int i = 1; i <= 15; i++) begin
        term = udiv_q(term * z, longint'(i) * one);
        if ((i % 2) == 1) sum = sum - term;
        else sum = sum + term;
      end
      if (sum < 0) sum = 0;
      for (int j = 0; j < 4; j++) sum = (sum * sum + (one >>> 1)) >>> 30;
      sum = (sum + (longint'(1) <<< 13)) >>> 14;
      if (sum > 65535) sum = 65535;
      rom[k] = sum[15:0];
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

FILE: sv/gpm_div.sv
// Restoring divider, one quotient bit per cycle, shared by both divisions.
// Depends on gpm_pkg.
module gpm_div (
  input  logic                        clk,
  input  logic                        rst,
  input  gpm_pkg::div_ctl_t           ctl,
  input  logic [gpm_pkg::DIV_W-1:0]   num,
  input  logic [gpm_pkg::DIV_W-1:0]   den,
  output gpm_pkg::div_sts_t           sts,
  output logic [gpm_pkg::DIV_W-1:0]   quot
);

  logic [gpm_pkg::DIV_W-1:0] rem;
  logic [gpm_pkg::DIV_W-1:0] nq;
  logic [gpm_pkg::DIV_W-1:0] dv;
  logic [5:0]                cnt;
  logic                      busy;
  logic                      done;
  logic [gpm_pkg::DIV_W:0]   t;
  logic                      ge;
  logic [gpm_pkg::DIV_W-1:0] rem_next;

  always_comb begin
    t = {rem, nq[gpm_pkg::DIV_W-1]};
    ge = t >= {1'b0, dv};
    rem_next = ge ? gpm_pkg::DIV_W'(t - {1'b0, dv}) : t[gpm_pkg::DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt <= ctl.bits;
        rem <= '0;
        dv <= den;
        nq <= num << (6'(gpm_pkg::DIV_W) - ctl.bits);
      end else if (busy) begin
        rem <= rem_next;
        nq <= {nq[gpm_pkg::DIV_W-2:0], ge};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign quot = nq;

endmodule

FILE: sv/gaussian_pixel_model_update_unit.sv
// One transaction at a time; the next is accepted as the result leaves. Throughput is set by the
// 1-bit-per-cycle divider (34 steps for distance, 45 for rho) and the shared 26x18 multiplier.
// Reset (rst, synchronous): means 0, variance 20.0, learn_rate 655, outputs empty.
// Depends on gpm_pkg and gpm_div.
module gaussian_pixel_model_update_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [25:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [7:0]  chan0,
  input  logic [7:0]  chan1,
  input  logic [7:0]  chan2,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        matched,
  output logic [23:0] norm_distance,
  output logic [15:0] update_weight,
  output logic [15:0] out_mean0,
  output logic [15:0] out_mean1,
  output logic [15:0] out_mean2,
  output logic [25:0] out_variance
);

  gpm_pkg::state_t state, state_next;

  logic [15:0] learn_rate;
  logic [25:0] initial_variance;
  logic [15:0] mean [3];
  logic [25:0] var_store;

  logic [1:0]  op;
  logic [7:0]  chan [3];
  logic [25:0] var_cur;
  logic [1:0]  cnt;
  logic        pass2;
  logic [47:0] acc;
  logic [43:0] prod;
  logic [23:0] norm;
  logic [15:0] rho;
  logic [25:0] sqv;

  logic [25:0] mul_a;
  logic [17:0] mul_b;
  logic        accept;
  logic [15:0] absd;
  logic [15:0] c8;
  logic [47:0] acc_sum;
  logic [36:0] idx_full;
  logic [15:0] exp_e;
  logic [47:0] blend_sum;
  logic [31:0] blend_res;
  logic [47:0] sq_round;

  gpm_pkg::div_ctl_t           div_ctl;
  gpm_pkg::div_sts_t           div_sts;
  logic [gpm_pkg::DIV_W-1:0]   div_num;
  logic [gpm_pkg::DIV_W-1:0]   div_den;
  logic [gpm_pkg::DIV_W-1:0]   div_quot;

  gpm_div u_div (
    .clk (clk),
    .rst (rst),
    .ctl (div_ctl),
    .num (div_num),
    .den (div_den),
    .sts (div_sts),
    .quot(div_quot)
  );

  assign in_stall = (state != gpm_pkg::ST_IDLE) || (out_valid && out_stall);
  assign accept = in_valid && !in_stall;

  always_comb begin
    c8 = {chan[cnt], 8'd0};
    absd = (c8 >= mean[cnt]) ? (c8 - mean[cnt]) : (mean[cnt] - c8);
    acc_sum = acc + 48'(prod);
    sq_round = (acc_sum + 48'd128) >> 8;
    idx_full = 37'(norm) * 37'(gpm_pkg::EXP_N);
    idx_full = idx_full >> 13;
    exp_e = (idx_full < 37'(gpm_pkg::EXP_N)) ? gpm_pkg::EXP_ROM[idx_full[gpm_pkg::IDX_W-1:0]]
                                             : 16'd0;
    blend_sum = acc + 48'(prod) + 48'd32768;
    blend_res = blend_sum[47:16];
  end

  always_comb begin
    state_next = state;
    mul_a = '0;
    mul_b = '0;
    div_ctl = '0;
    div_num = '0;
    div_den = '0;
    case (state)
      gpm_pkg::ST_IDLE: begin
        if (accept) state_next = gpm_pkg::ST_SQ_MUL;
      end
      gpm_pkg::ST_SQ_MUL: begin
        mul_a = 26'(absd);
        mul_b = 18'(absd);
        state_next = gpm_pkg::ST_SQ_ACC;
      end
      gpm_pkg::ST_SQ_ACC: begin
        if (cnt != 2'd2) state_next = gpm_pkg::ST_SQ_MUL;
        else if (pass2) state_next = gpm_pkg::ST_BL_OLD;
        else state_next = gpm_pkg::ST_ND_START;
      end
      gpm_pkg::ST_ND_START: begin
        div_ctl.start = 1'b1;
        div_ctl.bits = gpm_pkg::NORM_DIV_BITS;
        div_num = acc;
        div_den = 48'(var_cur);
        state_next = gpm_pkg::ST_ND_WAIT;
      end
      gpm_pkg::ST_ND_WAIT: begin
        if (div_sts.done) begin
          if (op == gpm_pkg::OP_ADJUST) state_next = gpm_pkg::ST_RHO_LR;
          else state_next = gpm_pkg::ST_DONE;
        end
      end
      gpm_pkg::ST_RHO_LR: begin
        mul_a = 26'(learn_rate);
        mul_b = 18'(exp_e);
        state_next = gpm_pkg::ST_RHO_DEN;
      end
      gpm_pkg::ST_RHO_DEN: begin
        mul_a = var_cur;
        mul_b = gpm_pkg::SQRT_2PI_Q16;
        state_next = gpm_pkg::ST_RD_START;
      end
      gpm_pkg::ST_RD_START: begin
        div_ctl.start = 1'b1;
        div_ctl.bits = gpm_pkg::RHO_DIV_BITS;
        div_num = acc + 48'(prod >> 1);
        div_den = 48'(prod);
        state_next = gpm_pkg::ST_RD_WAIT;
      end
      gpm_pkg::ST_RD_WAIT: begin
        if (div_sts.done) state_next = gpm_pkg::ST_BL_OLD;
      end
      gpm_pkg::ST_BL_OLD: begin
        mul_a = (cnt == 2'd3) ? var_cur : 26'(mean[cnt]);
        mul_b = 18'd65536 - 18'(rho);
        state_next = gpm_pkg::ST_BL_NEW;
      end
      gpm_pkg::ST_BL_NEW: begin
        mul_a = (cnt == 2'd3) ? sqv : 26'(c8);
        mul_b = 18'(rho);
        state_next = gpm_pkg::ST_BL_SUM;
      end
      gpm_pkg::ST_BL_SUM: begin
        if (cnt == 2'd3) state_next = gpm_pkg::ST_DONE;
        else if (cnt == 2'd2) state_next = gpm_pkg::ST_SQ_MUL;
        else state_next = gpm_pkg::ST_BL_OLD;
      end
      gpm_pkg::ST_DONE: begin
        state_next = gpm_pkg::ST_IDLE;
      end
      default: state_next = gpm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= gpm_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate <= gpm_pkg::LEARN_RATE_RST;
      initial_variance <= gpm_pkg::INIT_VAR_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        gpm_pkg::REG_LEARN_RATE: learn_rate <= cfg_data[15:0];
        gpm_pkg::REG_INIT_VAR: initial_variance <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mean[0] <= '0;
      mean[1] <= '0;
      mean[2] <= '0;
      var_store <= gpm_pkg::INIT_VAR_RST;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        gpm_pkg::ST_IDLE: begin
          if (accept) begin
            op <= operation;
            chan[0] <= chan0;
            chan[1] <= chan1;
            chan[2] <= chan2;
            var_cur <= (var_store != '0) ? var_store : 26'd1;
            cnt <= 2'd0;
            pass2 <= 1'b0;
            acc <= '0;
            rho <= '0;
          end
        end
        gpm_pkg::ST_SQ_ACC: begin
          acc <= acc_sum;
          if (cnt == 2'd2) begin
            if (pass2) begin
              cnt <= 2'd3;
              sqv <= (sq_round > 48'(gpm_pkg::VAR_MAX)) ? gpm_pkg::VAR_MAX : sq_round[25:0];
            end
          end else begin
            cnt <= cnt + 2'd1;
          end
        end
        gpm_pkg::ST_ND_WAIT: begin
          if (div_sts.done) begin
            norm <= (div_quot > 48'(gpm_pkg::DIST_MAX)) ? gpm_pkg::DIST_MAX : div_quot[23:0];
            if (op == gpm_pkg::OP_RESET) begin
              mean[0] <= {chan[0], 8'd0};
              mean[1] <= {chan[1], 8'd0};
              mean[2] <= {chan[2], 8'd0};
              var_store <= (initial_variance != '0) ? initial_variance : 26'd1;
            end
          end
        end
        gpm_pkg::ST_RHO_DEN: begin
          acc <= 48'(prod) << 8;
        end
        gpm_pkg::ST_RD_WAIT: begin
          if (div_sts.done) begin
            rho <= (div_quot > 48'd65535) ? 16'hFFFF : div_quot[15:0];
            cnt <= 2'd0;
          end
        end
        gpm_pkg::ST_BL_NEW: begin
          acc <= 48'(prod);
        end
        gpm_pkg::ST_BL_SUM: begin
          if (cnt == 2'd3) begin
            if (blend_res == '0) var_store <= 26'd1;
            else if (blend_res > 32'(gpm_pkg::VAR_MAX)) var_store <= gpm_pkg::VAR_MAX;
            else var_store <= blend_res[25:0];
          end else begin
            mean[cnt] <= blend_res[15:0];
            if (cnt == 2'd2) begin
              cnt <= 2'd0;
              pass2 <= 1'b1;
              acc <= '0;
            end else begin
              cnt <= cnt + 2'd1;
            end
          end
        end
        gpm_pkg::ST_DONE: begin
          out_valid <= 1'b1;
          matched <= norm <= gpm_pkg::MATCH_LIMIT;
          norm_distance <= norm;
          update_weight <= rho;
          out_mean0 <= mean[0];
          out_mean1 <= mean[1];
          out_mean2 <= mean[2];
          out_variance <= var_store;
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: sv/gpm_checker.sv
// Port-level checker for the Gaussian pixel model update unit, bound to the top level.
// Depends on gpm_pkg and gaussian_pixel_model_update_unit_macros.svh.
`include "gaussian_pixel_model_update_unit_macros.svh"
module gpm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        matched,
  input logic [23:0] norm_distance,
  input logic [25:0] out_variance
);

  `GPM_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "not busy after transaction")
  `GPM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
  `GPM_ASSERT_NOW(a_var_nonzero, out_valid, out_variance != 26'd0, "variance below floor")
  `GPM_ASSERT_NOW(a_match_consistent, out_valid, matched == (norm_distance <= gpm_pkg::MATCH_LIMIT), "match flag disagrees with distance")

endmodule

bind gaussian_pixel_model_update_unit gpm_checker u_gpm_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .matched      (matched),
  .norm_distance(norm_distance),
  .out_variance (out_variance)
);
